// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the divide unit modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MDU_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("divide unit check failed");

// antecedent implies consequent in the next cycle
`define MDU_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("divide unit check failed");

`endif

// ===== sv/mdu_pkg.sv =====
// ----------------------------------------------------------------------------
// mdu_pkg
// shared widths, latency and the stage record of the divide unit
// ----------------------------------------------------------------------------
`default_nettype none

package mdu_pkg;

    localparam int DW          = 32;
    localparam int MDU_LATENCY = DW + 2;

    localparam logic CMD_SIGNED   = 1'b0;
    localparam logic CMD_UNSIGNED = 1'b1;

    typedef struct packed {
        logic          valid;
        logic          neg_q;
        logic          neg_r;
        logic [DW-1:0] rem;
        logic [DW-1:0] num;
        logic [DW-1:0] dvs;
    } mdu_stage_t;

endpackage

`default_nettype wire

// ===== sv/mdu_prep.sv =====
// ----------------------------------------------------------------------------
// mdu_prep
// input stage: takes magnitudes and records the result signs
// ----------------------------------------------------------------------------
`default_nettype none

module mdu_prep (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  take,
    input  wire logic                  command,
    input  wire logic [31:0]           dividend,
    input  wire logic [31:0]           divisor,
    output mdu_pkg::mdu_stage_t        stage_out
);
    import mdu_pkg::*;

    logic          n_neg;
    logic          d_neg;
    logic          valid_reg, valid_next;
    logic          neg_q_reg, neg_q_next;
    logic          neg_r_reg, neg_r_next;
    logic [DW-1:0] num_reg, num_next;
    logic [DW-1:0] dvs_reg, dvs_next;

    always_comb
    begin
        n_neg      = (command == CMD_SIGNED) && dividend[DW-1];
        d_neg      = (command == CMD_SIGNED) && divisor[DW-1];
        valid_next = take;
        neg_q_next = n_neg ^ d_neg;
        neg_r_next = n_neg;
        num_next   = n_neg ? (~dividend + DW'(1)) : dividend;
        dvs_next   = d_neg ? (~divisor + DW'(1)) : divisor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        num_reg   <= num_next;
        dvs_reg   <= dvs_next;
    end

    always_comb
    begin
        stage_out.valid = valid_reg;
        stage_out.neg_q = neg_q_reg;
        stage_out.neg_r = neg_r_reg;
        stage_out.rem   = '0;
        stage_out.num   = num_reg;
        stage_out.dvs   = dvs_reg;
    end

endmodule

`default_nettype wire

// ===== sv/mdu_cell.sv =====
// ----------------------------------------------------------------------------
// mdu_cell
// one restoring division step: produces one quotient bit per cell
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mdu_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  mdu_pkg::mdu_stage_t stage_in,
    output mdu_pkg::mdu_stage_t stage_out
);
    import mdu_pkg::*;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          qbit;
    logic          valid_reg, valid_next;
    logic          neg_q_reg, neg_q_next;
    logic          neg_r_reg, neg_r_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] num_reg, num_next;
    logic [DW-1:0] dvs_reg, dvs_next;

    always_comb
    begin
        trial      = {stage_in.rem, stage_in.num[DW-1]};
        diff       = trial - {1'b0, stage_in.dvs};
        qbit       = ~diff[DW];
        valid_next = stage_in.valid;
        neg_q_next = stage_in.neg_q;
        neg_r_next = stage_in.neg_r;
        rem_next   = qbit ? diff[DW-1:0] : trial[DW-1:0];
        num_next   = {stage_in.num[DW-2:0], qbit};
        dvs_next   = stage_in.dvs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        rem_reg   <= rem_next;
        num_reg   <= num_next;
        dvs_reg   <= dvs_next;
    end

    always_comb
    begin
        stage_out.valid = valid_reg;
        stage_out.neg_q = neg_q_reg;
        stage_out.neg_r = neg_r_reg;
        stage_out.rem   = rem_reg;
        stage_out.num   = num_reg;
        stage_out.dvs   = dvs_reg;
    end

    // partial remainder stays below a nonzero divisor
    `MDU_ASSERT_SAME(a_rem_below_dvs, clk, rst_n, valid_reg && (dvs_reg != '0), rem_reg < dvs_reg)
    // divisor travels unchanged along the chain
    `MDU_ASSERT_NEXT(a_dvs_carried, clk, rst_n, stage_in.valid, valid_reg && (dvs_reg == $past(stage_in.dvs)))

endmodule

`default_nettype wire

// ===== sv/mdu_post.sv =====
// ----------------------------------------------------------------------------
// mdu_post
// output stage: applies result signs and drives the result strobe
// ----------------------------------------------------------------------------
`default_nettype none

module mdu_post (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  mdu_pkg::mdu_stage_t stage_in,
    output logic                done,
    output logic [31:0]         quotient,
    output logic [31:0]         remainder
);
    import mdu_pkg::*;

    logic          done_reg, done_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;

    always_comb
    begin
        done_next = stage_in.valid;
        quo_next  = stage_in.neg_q ? (~stage_in.num + DW'(1)) : stage_in.num;
        rem_next  = stage_in.neg_r ? (~stage_in.rem + DW'(1)) : stage_in.rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== sv/mips_divide_unit_core.sv =====
// ----------------------------------------------------------------------------
// mips_divide_unit_core
// 32-bit signed / unsigned divider, one request per cycle
// ----------------------------------------------------------------------------
// usage
//   request: drive command (0 signed, 1 unsigned), dividend and divisor
//   with start high; busy is always low, so every start is taken
//   result: done pulses for one cycle with quotient (lo) and remainder (hi)
//   pipeline: one input stage, 32 division cells (one quotient bit each)
//   and one sign fix-up stage
//   throughput: one request per cycle, results leave in request order
//   divide by zero: hi = dividend, lo = all ones (1 for a negative signed
//   dividend); signed 0x80000000 / -1 gives lo 0x80000000, hi 0
//   reset: clears all valid flags, requests in flight are dropped
//   the receiver cannot stall; done is not held off
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mips_divide_unit_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        command,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient,
    output logic [31:0]      remainder
);
    import mdu_pkg::*;

    mdu_stage_t chain [0:DW];
    logic       take;

    assign busy = 1'b0;
    assign take = start && !busy;

    mdu_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .command   (command),
        .dividend  (dividend),
        .divisor   (divisor),
        .stage_out (chain[0])
    );

    for (genvar i = 0; i < DW; i++)
    begin : g_cell
        mdu_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    mdu_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage_in  (chain[DW]),
        .done      (done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // every result goes back to a request taken a fixed latency earlier
    `MDU_ASSERT_SAME(a_done_has_request, clk, rst_n, done, $past(take, MDU_LATENCY))
    // unsigned divide by one returns the dividend unchanged
    `MDU_ASSERT_SAME(a_udiv_by_one, clk, rst_n, done && $past(command == CMD_UNSIGNED && divisor == 32'd1, MDU_LATENCY), (quotient == $past(dividend, MDU_LATENCY)) && (remainder == '0))

endmodule

`default_nettype wire
